// ===== hw/rtl/smpq_pkg.sv =====
// Shared constants and types for the sorted min-first priority queue.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package smpq_pkg;

  localparam int CAPACITY   = 16;
  localparam int TAG_WIDTH  = 16;
  localparam int KEY_WIDTH  = 24;
  localparam int CNT_WIDTH  = $clog2(CAPACITY + 1);
  localparam int PORT_TAG_W = 16;
  localparam int PORT_OCC_W = 5;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [TAG_WIDTH-1:0] tag;
  } smpq_entry_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic        push_en;
    logic        pop_en;
    smpq_entry_t entry;
  } smpq_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/smpq_cell.sv =====
// One slot of the sorted row: holds an entry, compares it with a pushed key
// and shifts toward its neighbors. Depends on smpq_pkg.
`default_nettype none

module smpq_cell
  import smpq_pkg::*;
(
  input  wire              clk,
  input  wire smpq_cmd_t   cmd,
  input  wire              occupied,
  input  wire              left_ge,
  input  wire smpq_entry_t left_entry,
  input  wire smpq_entry_t right_entry,
  output logic             ge,
  output smpq_entry_t      entry
);

  smpq_entry_t entry_r;
  smpq_entry_t entry_nxt;

  // An empty slot, or one whose key is not smaller, sits at or behind the insert point.
  assign ge    = !occupied || (entry_r.key >= cmd.entry.key);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.push_en && ge) begin
      // Take the left neighbor if it also moves back, else the new entry lands here.
      entry_nxt = left_ge ? left_entry : cmd.entry;
    end else if (cmd.pop_en) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_min_priority_queue.sv =====
// Sorted min-first priority queue: a row of smpq_cell slots plus the
// fill counter and result register. Depends on smpq_pkg and smpq_cell.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transfer:
//   in_opcode 0 pushes (in_key_in, in_tag_in), 1 pops the smallest entry.
//   Every command yields exactly one result on the out_ channel
//   (out_valid / out_stall): the popped entry on a successful pop, zeros
//   otherwise, out_push_rejected on a push into a full queue, and the
//   occupancy after the command.
//   The result is registered at the edge that takes the command.
//   Throughput is one command per cycle while in_stall is low; all cells
//   compare against the pushed key in parallel and shift by one slot in
//   the same cycle.
//   While the result register is full and out_stall is high, in_stall is
//   raised and the queue holds its contents.
//   Reset (rst_n low, synchronous) empties the queue and the result
//   register; slot contents are left as they are and only read below the
//   fill count.
`default_nettype none

module sorted_min_priority_queue
  import smpq_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire                   in_opcode,
  input  wire  [KEY_WIDTH-1:0]  in_key_in,
  input  wire  [PORT_TAG_W-1:0] in_tag_in,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic                  out_entry_valid,
  output logic [KEY_WIDTH-1:0]  out_entry_key,
  output logic [PORT_TAG_W-1:0] out_entry_tag,
  output logic                  out_push_rejected,
  output logic [PORT_OCC_W-1:0] out_occupancy
);

  logic                 accept;
  logic                 is_full;
  logic                 is_empty;
  smpq_cmd_t            cmd;
  smpq_entry_t          cell_entry [CAPACITY];
  logic [CAPACITY-1:0]  cell_ge;

  logic [CNT_WIDTH-1:0]  count_r,     count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  res_valid_r, res_valid_nxt;
  logic [KEY_WIDTH-1:0]  res_key_r,   res_key_nxt;
  logic [TAG_WIDTH-1:0]  res_tag_r,   res_tag_nxt;
  logic                  res_rej_r,   res_rej_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_full  = (count_r == CNT_WIDTH'(CAPACITY));
  assign is_empty = (count_r == '0);

  assign cmd.push_en   = accept && (in_opcode == OP_PUSH) && !is_full;
  assign cmd.pop_en    = accept && (in_opcode == OP_POP) && !is_empty;
  assign cmd.entry.key = in_key_in;
  assign cmd.entry.tag = TAG_WIDTH'(in_tag_in);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic        left_ge;
    smpq_entry_t left_entry;
    smpq_entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_ge    = 1'b0;
      assign left_entry = cmd.entry;
    end else begin : g_body
      assign left_ge    = cell_ge[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_link
      assign right_entry = cell_entry[i+1];
    end

    smpq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (count_r > CNT_WIDTH'(i)),
      .left_ge     (left_ge),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .ge          (cell_ge[i]),
      .entry       (cell_entry[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    res_valid_nxt = res_valid_r;
    res_key_nxt   = res_key_r;
    res_tag_nxt   = res_tag_r;
    res_rej_nxt   = res_rej_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      res_valid_nxt = cmd.pop_en;
      res_key_nxt   = cmd.pop_en ? cell_entry[0].key : '0;
      res_tag_nxt   = cmd.pop_en ? cell_entry[0].tag : '0;
      res_rej_nxt   = (in_opcode == OP_PUSH) && is_full;
      if (cmd.push_en) begin
        count_nxt = count_r + CNT_WIDTH'(1);
      end else if (cmd.pop_en) begin
        count_nxt = count_r - CNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_valid_r <= res_valid_nxt;
    res_key_r   <= res_key_nxt;
    res_tag_r   <= res_tag_nxt;
    res_rej_r   <= res_rej_nxt;
  end

  // Occupancy reports after the command, so it follows the updated count.
  logic [CNT_WIDTH-1:0] occ_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      occ_r <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_entry_valid   = res_valid_r;
  assign out_entry_key     = res_key_r;
  assign out_entry_tag     = PORT_TAG_W'(res_tag_r);
  assign out_push_rejected = res_rej_r;
  assign out_occupancy     = PORT_OCC_W'(occ_r);

endmodule

`default_nettype wire

// ===== test/tb_sorted_min_priority_queue.sv =====
// Self-checking bench for sorted_min_priority_queue: a shadow sorted queue predicts
// every result, with bursty sender and pattern-stalled receiver. Depends on smpq_pkg.
`timescale 1ns / 1ps

module tb_sorted_min_priority_queue;
  import smpq_pkg::*;

  typedef struct {
    logic                  op;
    logic [KEY_WIDTH-1:0]  key;
    logic [PORT_TAG_W-1:0] tag;
    bit                    wait_idle;
  } pq_cmd_t;

  typedef struct {
    logic                  entry_valid;
    logic [KEY_WIDTH-1:0]  key;
    logic [PORT_TAG_W-1:0] tag;
    logic                  rejected;
    logic [PORT_OCC_W-1:0] occ;
  } pq_result_t;

  localparam logic [KEY_WIDTH-1:0]  KEY_MAX = '1;
  localparam logic [PORT_TAG_W-1:0] TAG_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_opcode = OP_PUSH;
  logic [KEY_WIDTH-1:0]  in_key_in = '0;
  logic [PORT_TAG_W-1:0] in_tag_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_entry_valid;
  logic [KEY_WIDTH-1:0]  out_entry_key;
  logic [PORT_TAG_W-1:0] out_entry_tag;
  logic                  out_push_rejected;
  logic [PORT_OCC_W-1:0] out_occupancy;

  sorted_min_priority_queue uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_key_in         (in_key_in),
    .in_tag_in         (in_tag_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_entry_valid   (out_entry_valid),
    .out_entry_key     (out_entry_key),
    .out_entry_tag     (out_entry_tag),
    .out_push_rejected (out_push_rejected),
    .out_occupancy     (out_occupancy)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pq_cmd_t     cmd_backlog[$];
  pq_result_t  expected_results[$];
  smpq_entry_t shadow_slots [CAPACITY];
  int          shadow_count = 0;
  int          mismatches = 0;
  int          results_checked = 0;
  int          burst_left = 1;
  int          gap_left = 0;

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatches < 40)
      $display("ERROR: result %0d field %s got 0x%0h expected 0x%0h",
               results_checked, field, got, want);
    mismatches++;
  endtask

  task automatic add_cmd(input logic op, input logic [KEY_WIDTH-1:0] key,
                         input logic [PORT_TAG_W-1:0] tag, input bit wait_idle);
    pq_cmd_t c;
    c.op = op;
    c.key = key;
    c.tag = tag;
    c.wait_idle = wait_idle;
    cmd_backlog.push_back(c);
  endtask

  // Apply one command to the shadow queue and queue up the result it yields.
  task automatic update_shadow_queue(input pq_cmd_t c);
    pq_result_t r;
    int pos;
    r.entry_valid = 1'b0;
    r.key = '0;
    r.tag = '0;
    r.rejected = 1'b0;
    if (c.op == OP_PUSH) begin
      if (shadow_count >= CAPACITY) begin
        r.rejected = 1'b1;
      end else begin
        // insert ahead of equal keys so that they pop newest first
        pos = 0;
        while (pos < shadow_count && shadow_slots[pos].key < c.key) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
        shadow_slots[pos].key = c.key;
        shadow_slots[pos].tag = c.tag;
        shadow_count++;
      end
    end else if (shadow_count > 0) begin
      r.entry_valid = 1'b1;
      r.key = shadow_slots[0].key;
      r.tag = shadow_slots[0].tag;
      for (int i = 1; i < shadow_count; i++) shadow_slots[i-1] = shadow_slots[i];
      shadow_count--;
    end
    r.occ = PORT_OCC_W'(shadow_count);
    expected_results.push_back(r);
  endtask

  function automatic logic [KEY_WIDTH-1:0] pick_key();
    case ($urandom_range(0, 5))
      0, 1: pick_key = KEY_WIDTH'($urandom_range(0, 7));
      2:    pick_key = ($urandom_range(0, 1) == 0) ? '0 : KEY_MAX;
      default: pick_key = KEY_WIDTH'($urandom);
    endcase
  endfunction

  // Driver: hold the payload while stalled, otherwise offer the next command
  // in bursts with random gaps.
  always @(posedge clk) begin
    logic offering;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        update_shadow_queue(cmd_backlog.pop_front());
        offering = 1'b0;
      end
      if (!offering && cmd_backlog.size() > 0 &&
          !(cmd_backlog[0].wait_idle && (expected_results.size() != 0 || out_valid))) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          offering = 1'b1;
          in_opcode <= cmd_backlog[0].op;
          in_key_in <= cmd_backlog[0].key;
          in_tag_in <= cmd_backlog[0].tag;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
          end
        end
      end
      in_valid <= offering;
    end
  end

  // Receiver: stall on stretches of different density, plus two long hold-offs
  // that let the queue back up into in_stall.
  int rx_seen = 0;
  int hold_left = 0;
  int pat_left = 0;
  int pat_mode = 0;

  always @(posedge clk) begin
    logic stall_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        rx_seen++;
        if (rx_seen == 250 || rx_seen == 650) hold_left = 100;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 2);
          pat_left = $urandom_range(20, 60);
        end
        pat_left--;
        case (pat_mode)
          0:       stall_next = 1'b0;
          1:       stall_next = ($urandom_range(0, 1) == 0);
          default: stall_next = ($urandom_range(0, 4) != 0);
        endcase
      end
      out_stall <= stall_next;
    end
  end

  // Monitor: compare each transfer against the oldest expectation.
  always @(posedge clk) begin
    pq_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected_transfer", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_entry_valid !== want.entry_valid)
          report_mismatch("entry_valid", out_entry_valid, want.entry_valid);
        if (out_entry_key !== want.key)
          report_mismatch("entry_key", out_entry_key, want.key);
        if (out_entry_tag !== want.tag)
          report_mismatch("entry_tag", out_entry_tag, want.tag);
        if (out_push_rejected !== want.rejected)
          report_mismatch("push_rejected", out_push_rejected, want.rejected);
        if (out_occupancy !== want.occ)
          report_mismatch("occupancy", out_occupancy, want.occ);
      end
      results_checked++;
    end
  end

  initial begin
    #2_400_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int seg_left;
    int seg_mode;
    int push_pct;
    logic op;

    // directed: empty pop, extreme fields, equal keys, fill, full push
    add_cmd(OP_POP, KEY_MAX, TAG_MAX, 1'b0);
    add_cmd(OP_PUSH, KEY_MAX, TAG_MAX, 1'b0);
    add_cmd(OP_PUSH, '0, '0, 1'b0);
    add_cmd(OP_PUSH, 24'd100, 16'h00a1, 1'b0);
    add_cmd(OP_PUSH, 24'd100, 16'h00a2, 1'b0);
    add_cmd(OP_PUSH, 24'd100, 16'h00a3, 1'b0);
    for (int i = 0; i < 10; i++)
      add_cmd(OP_PUSH, (i % 3 == 0) ? '0 : KEY_WIDTH'(200 - i * 7), PORT_TAG_W'(16'h5a00 + i),
              1'b0);
    add_cmd(OP_PUSH, 24'd1, 16'hdead, 1'b0);
    add_cmd(OP_POP, '0, '0, 1'b0);
    add_cmd(OP_PUSH, 24'd100, 16'h00a4, 1'b0);
    add_cmd(OP_PUSH, KEY_MAX, 16'hbeef, 1'b0);

    // random: segments biased toward filling, draining or mixing
    seg_left = 0;
    seg_mode = 0;
    for (int n = 0; n < 950; n++) begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 2);
        seg_left = $urandom_range(8, 40);
      end
      seg_left--;
      case (seg_mode)
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      add_cmd(op, pick_key(), PORT_TAG_W'($urandom), (n % 300 == 0));
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
